### rtl/min_tracking_stack_unit_assert.svh
// ----------------------------------------------------------------------------
// Min tracking stack assertion macros
// Shared macros for the concurrent checks in the stack modules.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_UNIT_ASSERT_SVH
`define MIN_TRACKING_STACK_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// Min tracking stack package
// Types and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int VALUE_W  = 32;
   localparam int DEPTH_W  = 9;
   localparam int STATUS_W = 2;
   localparam int RSP_W    = 80;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] minimum;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic pop_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic deep;
   } sts_type;

endpackage

### rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// Min tracking stack controller
// Handshake control, pop sequencing and the result valid flag.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_unit_assert.svh"

module mts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_func,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  mts_pkg::sts_type sts,
   output mts_pkg::cmd_type cmd
);
   import mts_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_tvalid_ff;
   logic rsp_tvalid_in;
   logic accept;
   logic deep_pop;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign deep_pop   = accept && (req_func == FUNC_POP) && sts.deep;

   assign cmd.push     = accept && (req_func == FUNC_PUSH);
   assign cmd.pop      = accept && (req_func == FUNC_POP);
   assign cmd.pop_load = (state_ff == S_POP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (deep_pop) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid_in = (accept && !deep_pop) || cmd.pop_load ||
                          (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tvalid    = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `MTS_ASSERT_SAME(a_no_accept_during_pop, clock, reset, state_ff == S_POP, !req_tready, "transaction accepted during a pop read")
   `MTS_ASSERT_NEXT(a_pop_gives_result, clock, reset, state_ff == S_POP, rsp_tvalid_ff, "pop read produced no result")

endmodule

### rtl/mts_dpath.sv
// ----------------------------------------------------------------------------
// Min tracking stack datapath
// Entry memory, cached top entry, fill counter and result register.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_unit_assert.svh"

module mts_dpath #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mts_pkg::cmd_type                     cmd,
   output mts_pkg::sts_type                     sts,
   input  logic signed [mts_pkg::VALUE_W-1:0]   req_value,
   output logic signed [mts_pkg::VALUE_W-1:0]   out_top,
   output logic signed [mts_pkg::VALUE_W-1:0]   out_min,
   output logic [mts_pkg::DEPTH_W-1:0]          out_depth,
   output logic                                 out_empty,
   output logic [mts_pkg::STATUS_W-1:0]         out_status
);
   import mts_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   entry_type mem [STACK_DEPTH];

   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [CW-1:0]              below_idx;
   logic signed [VALUE_W-1:0]  top_value_ff;
   logic signed [VALUE_W-1:0]  top_value_in;
   logic signed [VALUE_W-1:0]  top_min_ff;
   logic signed [VALUE_W-1:0]  top_min_in;
   logic signed [VALUE_W-1:0]  new_min;
   entry_type                  rd_ff;
   logic signed [VALUE_W-1:0]  out_top_ff;
   logic signed [VALUE_W-1:0]  out_top_in;
   logic signed [VALUE_W-1:0]  out_min_ff;
   logic signed [VALUE_W-1:0]  out_min_in;
   logic [DEPTH_W-1:0]         out_depth_ff;
   logic [DEPTH_W-1:0]         out_depth_in;
   logic                       out_empty_ff;
   logic                       out_empty_in;
   logic [STATUS_W-1:0]        out_status_ff;
   logic [STATUS_W-1:0]        out_status_in;
   logic                       out_load;
   logic                       push_ok;

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == CW'(STACK_DEPTH));
   assign sts.deep  = (count_ff >= CW'(2));

   assign push_ok   = cmd.push && !sts.full;
   assign below_idx = count_ff - CW'(2);
   assign new_min   = (sts.empty || (req_value < top_min_ff)) ? req_value : top_min_ff;

   always_comb begin
      count_in      = count_ff;
      top_value_in  = top_value_ff;
      top_min_in    = top_min_ff;
      out_load      = 1'b0;
      out_top_in    = out_top_ff;
      out_min_in    = out_min_ff;
      out_depth_in  = out_depth_ff;
      out_empty_in  = out_empty_ff;
      out_status_in = out_status_ff;
      if (cmd.push) begin
         out_load = 1'b1;
         if (sts.full) begin
            out_top_in    = top_value_ff;
            out_min_in    = top_min_ff;
            out_depth_in  = DEPTH_W'(count_ff);
            out_empty_in  = 1'b0;
            out_status_in = STATUS_PUSH_FULL;
         end else begin
            count_in      = count_ff + CW'(1);
            top_value_in  = req_value;
            top_min_in    = new_min;
            out_top_in    = req_value;
            out_min_in    = new_min;
            out_depth_in  = DEPTH_W'(count_in);
            out_empty_in  = 1'b0;
            out_status_in = STATUS_OK;
         end
      end else if (cmd.pop) begin
         if (sts.empty) begin
            out_load      = 1'b1;
            out_top_in    = '0;
            out_min_in    = '0;
            out_depth_in  = '0;
            out_empty_in  = 1'b1;
            out_status_in = STATUS_POP_EMPTY;
         end else begin
            count_in = count_ff - CW'(1);
            if (!sts.deep) begin
               out_load      = 1'b1;
               out_top_in    = '0;
               out_min_in    = '0;
               out_depth_in  = '0;
               out_empty_in  = 1'b1;
               out_status_in = STATUS_OK;
            end
         end
      end else if (cmd.pop_load) begin
         top_value_in  = rd_ff.value;
         top_min_in    = rd_ff.minimum;
         out_load      = 1'b1;
         out_top_in    = rd_ff.value;
         out_min_in    = rd_ff.minimum;
         out_depth_in  = DEPTH_W'(count_ff);
         out_empty_in  = 1'b0;
         out_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[count_ff[AW-1:0]] <= '{value: req_value, minimum: new_min};
      end
      if (cmd.pop && sts.deep) begin
         rd_ff <= mem[below_idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      top_value_ff <= top_value_in;
      top_min_ff   <= top_min_in;
      if (out_load) begin
         out_top_ff    <= out_top_in;
         out_min_ff    <= out_min_in;
         out_depth_ff  <= out_depth_in;
         out_empty_ff  <= out_empty_in;
         out_status_ff <= out_status_in;
      end
   end

   assign out_top    = out_top_ff;
   assign out_min    = out_min_ff;
   assign out_depth  = out_depth_ff;
   assign out_empty  = out_empty_ff;
   assign out_status = out_status_ff;

   `MTS_ASSERT_NEXT(a_refused_push_holds, clock, reset, cmd.push && sts.full, $stable(count_ff), "refused push changed the fill count")
   `MTS_ASSERT_NEXT(a_push_grows, clock, reset, push_ok, count_ff == $past(count_ff) + CW'(1), "accepted push did not grow the stack")
   `MTS_ASSERT_SAME(a_min_not_above_top, clock, reset, !sts.empty && !cmd.pop_load, top_min_ff <= top_value_ff, "cached minimum exceeds cached top")

endmodule

### rtl/min_tracking_stack_unit.sv
// ----------------------------------------------------------------------------
// Min tracking stack unit
// LIFO stack of signed 32-bit values that reports the running minimum.
// ----------------------------------------------------------------------------
// Each request transaction is a push (req_tuser low) or a pop (req_tuser high)
// and produces exactly one response transaction with the top value, the
// minimum, the depth, an empty flag and a status. A push, a pop on an empty
// stack and a pop that empties the stack are answered from the registered
// result directly; a pop that leaves entries behind first waits in the pop
// read state for the registered read of the entry memory that reloads the
// cached top entry. A new request is taken in the same cycle that the previous
// response is taken. Top and minimum read as zero when the stack is empty.
module min_tracking_stack_unit #(
   parameter int STACK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [31:0] top_value, [63:32] min_value,
                                    // [72:64] fill_depth, [73] is_empty,
                                    // [75:74] status, [79:76] zero
);
   import mts_pkg::*;

   cmd_type                    cmd;
   sts_type                    sts;
   logic signed [VALUE_W-1:0]  out_top;
   logic signed [VALUE_W-1:0]  out_min;
   logic [DEPTH_W-1:0]         out_depth;
   logic                       out_empty;
   logic [STATUS_W-1:0]        out_status;

   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mts_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_value  ($signed(req_tdata)),
      .out_top    (out_top),
      .out_min    (out_min),
      .out_depth  (out_depth),
      .out_empty  (out_empty),
      .out_status (out_status)
   );

   assign rsp_tdata = {4'b0000, out_status, out_empty, out_depth, out_min, out_top};

endmodule

### tb/sv/min_tracking_stack_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Min tracking stack unit testbench
// Drives push and pop transactions into the stack and checks every response
// against a behavioral stack model kept in the bench. The run covers empty
// and full corner cases and four flow-control phases, including a long
// response hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit_tb;
   import mts_pkg::*;

   localparam int STACK_ENTRIES = 256;
   localparam int OPS_PER_PHASE = 470;
   localparam int HOLD_CYCLES   = 300;

   typedef struct {
      logic                      func;
      logic signed [VALUE_W-1:0] value;
   } stack_op_type;

   typedef struct {
      logic signed [VALUE_W-1:0] top;
      logic signed [VALUE_W-1:0] minimum;
      logic [DEPTH_W-1:0]        depth;
      logic                      empty;
      logic [STATUS_W-1:0]       status;
      logic [3:0]                pad;
   } stack_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   stack_op_type  pending_ops[$];
   stack_rsp_type expected_rsp[$];
   stack_op_type  next_op;
   stack_rsp_type seen_rsp;
   stack_rsp_type due_rsp;

   logic signed [VALUE_W-1:0] stack_values [STACK_ENTRIES];
   logic signed [VALUE_W-1:0] stack_minima [STACK_ENTRIES];
   int stack_count   = 0;
   int plan_depth    = 0;
   int req_accepted  = 0;
   int error_count   = 0;
   int sender_idle   = 0;
   int receiver_stall = 0;
   int hold_left     = 0;
   logic hold_start  = 1'b0;

   min_tracking_stack_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic stack_rsp_type apply_stack_op(logic func,
                                                    logic signed [VALUE_W-1:0] value);
      stack_rsp_type r;
      logic signed [VALUE_W-1:0] floor_min;
      r.status = STATUS_OK;
      r.pad    = '0;
      if (func == FUNC_PUSH) begin
         if (stack_count >= STACK_ENTRIES) begin
            r.status = STATUS_PUSH_FULL;
         end else begin
            floor_min = value;
            if (stack_count > 0 && stack_minima[stack_count-1] < value) begin
               floor_min = stack_minima[stack_count-1];
            end
            stack_values[stack_count] = value;
            stack_minima[stack_count] = floor_min;
            stack_count++;
         end
      end else if (stack_count == 0) begin
         r.status = STATUS_POP_EMPTY;
      end else begin
         stack_count--;
      end
      r.top     = (stack_count > 0) ? stack_values[stack_count-1] : '0;
      r.minimum = (stack_count > 0) ? stack_minima[stack_count-1] : '0;
      r.depth   = stack_count[DEPTH_W-1:0];
      r.empty   = (stack_count == 0);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: mismatch on %s: expected 0x%08h, got 0x%08h",
                     $realtime, name, want, got);
         end
      end
   endtask

   // Planning keeps its own depth so that fill and drain runs end exactly
   // at the full and empty boundaries.
   task automatic queue_op(logic func, logic signed [VALUE_W-1:0] value);
      stack_op_type op;
      op.func  = func;
      op.value = value;
      pending_ops.insert(pending_ops.size(), op);
      if (func == FUNC_PUSH && plan_depth < STACK_ENTRIES) begin
         plan_depth++;
      end else if (func == FUNC_POP && plan_depth > 0) begin
         plan_depth--;
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(3))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7fff_ffff;
               2: v = 32'sh0000_0000;
               default: v = -32'sd1;
            endcase
         end
         1: v = $signed($urandom_range(15)) - 32'sd8;
         default: v = $signed($urandom);
      endcase
      return v;
   endfunction

   task automatic plan_phase(bit start_with_fill);
      int n;
      int run;
      int push_pct;
      n = 0;
      if (start_with_fill) begin
         while (plan_depth < STACK_ENTRIES) begin
            queue_op(FUNC_PUSH, pick_value());
            n++;
         end
         run = $urandom_range(4, 1);
         repeat (run) queue_op(FUNC_PUSH, pick_value());
         n += run;
      end else begin
         while (plan_depth > 0) begin
            queue_op(FUNC_POP, $signed($urandom));
            n++;
         end
         run = $urandom_range(3, 1);
         repeat (run) queue_op(FUNC_POP, $signed($urandom));
         n += run;
      end
      while (n < OPS_PER_PHASE) begin
         run = $urandom_range(40, 10);
         for (int i = 0; i < run; i++) begin
            if (plan_depth < 16) push_pct = 70;
            else if (plan_depth > 240) push_pct = 30;
            else push_pct = 55;
            if ($urandom_range(99) < push_pct) queue_op(FUNC_PUSH, pick_value());
            else queue_op(FUNC_POP, $signed($urandom));
         end
         n += run;
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= sender_idle) begin
            next_op = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_op.func;
            req_tdata  <= next_op.value;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_start && hold_left == 0 && $urandom_range(99) >= receiver_stall;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsp.insert(expected_rsp.size(), apply_stack_op(req_tuser, req_tdata));
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.top     = rsp_tdata[31:0];
            seen_rsp.minimum = rsp_tdata[63:32];
            seen_rsp.depth   = rsp_tdata[72:64];
            seen_rsp.empty   = rsp_tdata[73];
            seen_rsp.status  = rsp_tdata[75:74];
            seen_rsp.pad     = rsp_tdata[79:76];
            if (expected_rsp.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: response transaction with none expected: 0x%020h",
                           $realtime, rsp_tdata);
               end
            end else begin
               due_rsp = expected_rsp.pop_front();
               check_field("top_value", due_rsp.top, seen_rsp.top);
               check_field("min_value", due_rsp.minimum, seen_rsp.minimum);
               check_field("fill_depth", due_rsp.depth, seen_rsp.depth);
               check_field("is_empty", due_rsp.empty, seen_rsp.empty);
               check_field("status", due_rsp.status, seen_rsp.status);
               check_field("padding", due_rsp.pad, seen_rsp.pad);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops on empty, extreme values, equal minima, and pops
      // that leave entries behind as well as pops that empty the stack.
      queue_op(FUNC_POP, 32'sh7fff_ffff);
      queue_op(FUNC_POP, 32'sh8000_0000);
      queue_op(FUNC_PUSH, 32'sd5);
      queue_op(FUNC_PUSH, 32'sh7fff_ffff);
      queue_op(FUNC_PUSH, 32'sh8000_0000);
      queue_op(FUNC_PUSH, 32'sh8000_0000);
      queue_op(FUNC_PUSH, -32'sd1);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, -32'sd1);
      queue_op(FUNC_PUSH, 32'sd0);
      queue_op(FUNC_PUSH, -32'sd3);
      queue_op(FUNC_PUSH, -32'sd3);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_PUSH, 32'sd7);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);
      queue_op(FUNC_POP, 32'sd0);

      for (int phase = 0; phase < 4; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin
               sender_idle    <= 0;
               receiver_stall <= 0;
            end
            1: begin
               sender_idle    <= 78;
               receiver_stall <= 0;
            end
            2: begin
               sender_idle    <= 0;
               receiver_stall <= 78;
            end
            default: begin
               sender_idle    <= 22;
               receiver_stall <= 22;
            end
         endcase
         plan_phase(phase % 2 == 0);
         if (phase == 0) begin
            wait (req_accepted >= 60);
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
